FILE: rtl/asp_pkg.sv
// Shared types, constants and helpers for the affinity priority scheduler queue.
package asp_pkg;

  localparam int Capacity = 16;
  localparam int IdxW     = $clog2(Capacity);
  localparam int CntW     = $clog2(Capacity + 1);
  localparam int TimeW    = 24;
  localparam int NiceW    = 6;
  localparam int MaskW    = 16;
  localparam int IdW      = 16;
  localparam int KeyW     = TimeW + NiceW;
  localparam int BitsW    = $clog2(MaskW + 1);

  localparam logic [NiceW-1:0] NiceLow  = NiceW'(10);
  localparam logic [NiceW-1:0] NiceEnd  = NiceW'(50);
  localparam logic [TimeW-1:0] TimeMax  = {TimeW{1'b1}};
  localparam logic [MaskW-1:0] CpuBits  = {MaskW{1'b1}};

  localparam logic [2:0] FN_PUSH   = 3'd0;
  localparam logic [2:0] FN_PEEK   = 3'd1;
  localparam logic [2:0] FN_POP    = 3'd2;
  localparam logic [2:0] FN_RUN    = 3'd3;
  localparam logic [2:0] FN_RENICE = 3'd4;

  localparam logic [2:0] ST_OK    = 3'd0;
  localparam logic [2:0] ST_DUP   = 3'd1;
  localparam logic [2:0] ST_INCON = 3'd2;
  localparam logic [2:0] ST_FULL  = 3'd3;
  localparam logic [2:0] ST_NONE  = 3'd4;

  typedef struct packed {
    logic [IdW-1:0]   id;
    logic [TimeW-1:0] rem;
    logic [NiceW-1:0] nice;
    logic [MaskW-1:0] mask;
  } entry_t;

  typedef enum logic [1:0] {
    SEL_SLOT,
    SEL_ID,
    SEL_NONE
  } emit_sel_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_FIND,
    S_HIT,
    S_KEY,
    S_SEEK,
    S_EMIT
  } state_t;

  typedef struct packed {
    logic       latch;
    logic       scan_rst;
    logic       scan_inc;
    logic       mark;
    logic       load_new;
    logic       remove;
    logic       upd_run;
    logic       upd_nice;
    logic       calc_key;
    logic       place;
    logic       emit;
    logic [2:0] status;
    emit_sel_t  sel;
  } dp_cmd_t;

  typedef struct packed {
    logic [2:0] func;
    logic       scan_end;
    logic       id_hit;
    logic       q_hit;
    logic       go_past;
    logic       full;
    logic       same;
    logic       cb_zero;
  } dp_stat_t;

  function automatic logic [NiceW-1:0] clamp_nice(input logic [NiceW-1:0] v);
    if (v < NiceLow) return NiceLow;
    if (v >= NiceEnd) return NiceEnd - NiceW'(1);
    return v;
  endfunction

endpackage

FILE: rtl/asp_ctrl.sv
// Controller state machine sequencing scans, removal and sorted insertion.
module asp_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  output logic              busy,
  input  asp_pkg::dp_stat_t stat,
  output asp_pkg::dp_cmd_t  cmd
);

  asp_pkg::state_t    state_r, state_nxt;
  logic [2:0]         st_r, st_nxt;
  asp_pkg::emit_sel_t sel_r, sel_nxt;
  logic               valid_op, hit;

  assign valid_op = (stat.func <= asp_pkg::FN_RENICE);
  assign hit = (stat.func == asp_pkg::FN_PUSH || stat.func == asp_pkg::FN_RENICE) ?
               stat.id_hit : stat.q_hit;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= asp_pkg::S_IDLE;
      st_r    <= asp_pkg::ST_NONE;
      sel_r   <= asp_pkg::SEL_NONE;
    end else begin
      state_r <= state_nxt;
      st_r    <= st_nxt;
      sel_r   <= sel_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    st_nxt    = st_r;
    sel_nxt   = sel_r;
    unique case (state_r)
      asp_pkg::S_IDLE: if (start) state_nxt = asp_pkg::S_FIND;
      asp_pkg::S_FIND: begin
        if (!valid_op) begin
          st_nxt = asp_pkg::ST_NONE; sel_nxt = asp_pkg::SEL_NONE;
          state_nxt = asp_pkg::S_EMIT;
        end else if (stat.scan_end) begin
          if (stat.func != asp_pkg::FN_PUSH) begin
            st_nxt = asp_pkg::ST_NONE; sel_nxt = asp_pkg::SEL_NONE;
            state_nxt = asp_pkg::S_EMIT;
          end else if (stat.full) begin
            st_nxt = asp_pkg::ST_FULL; sel_nxt = asp_pkg::SEL_ID;
            state_nxt = asp_pkg::S_EMIT;
          end else begin
            st_nxt = asp_pkg::ST_OK; sel_nxt = asp_pkg::SEL_SLOT;
            state_nxt = asp_pkg::S_KEY;
          end
        end else if (hit) begin
          state_nxt = asp_pkg::S_HIT;
        end
      end
      asp_pkg::S_HIT: begin
        sel_nxt = asp_pkg::SEL_SLOT;
        st_nxt  = asp_pkg::ST_OK;
        state_nxt = asp_pkg::S_EMIT;
        if (stat.func == asp_pkg::FN_PUSH)
          st_nxt = stat.same ? asp_pkg::ST_DUP : asp_pkg::ST_INCON;
        else if (stat.func == asp_pkg::FN_RENICE ||
                 (stat.func == asp_pkg::FN_RUN && !stat.cb_zero))
          state_nxt = asp_pkg::S_KEY;
      end
      asp_pkg::S_KEY:  state_nxt = asp_pkg::S_SEEK;
      asp_pkg::S_SEEK: if (stat.scan_end || !stat.go_past) state_nxt = asp_pkg::S_EMIT;
      asp_pkg::S_EMIT: state_nxt = asp_pkg::S_IDLE;
      default:         state_nxt = asp_pkg::S_IDLE;
    endcase
  end

  always_comb begin
    cmd = '0;
    cmd.status = st_r;
    cmd.sel = sel_r;
    busy = (state_r != asp_pkg::S_IDLE);
    unique case (state_r)
      asp_pkg::S_IDLE: if (start) begin
        cmd.latch = 1'b1; cmd.scan_rst = 1'b1;
      end
      asp_pkg::S_FIND: begin
        if (valid_op && stat.scan_end && stat.func == asp_pkg::FN_PUSH && !stat.full)
          cmd.load_new = 1'b1;
        else if (valid_op && !stat.scan_end && hit)
          cmd.mark = 1'b1;
        else if (valid_op && !stat.scan_end)
          cmd.scan_inc = 1'b1;
      end
      asp_pkg::S_HIT: begin
        if (stat.func == asp_pkg::FN_POP) cmd.remove = 1'b1;
        if (stat.func == asp_pkg::FN_RUN) begin
          cmd.remove = 1'b1; cmd.upd_run = 1'b1;
        end
        if (stat.func == asp_pkg::FN_RENICE) begin
          cmd.remove = 1'b1; cmd.upd_nice = 1'b1;
        end
      end
      asp_pkg::S_KEY: begin
        cmd.calc_key = 1'b1; cmd.scan_rst = 1'b1;
      end
      asp_pkg::S_SEEK: begin
        if (stat.scan_end || !stat.go_past) cmd.place = 1'b1;
        else cmd.scan_inc = 1'b1;
      end
      asp_pkg::S_EMIT: cmd.emit = 1'b1;
      default: ;
    endcase
  end

endmodule

FILE: rtl/asp_datapath.sv
// Datapath: sorted entry table, scan index, working slot, key compare and result registers.
module asp_datapath (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic [2:0]                  in_func,
  input  logic [asp_pkg::IdW-1:0]     in_proc_id,
  input  logic [asp_pkg::TimeW-1:0]   in_time_left,
  input  logic [asp_pkg::NiceW-1:0]   in_niceness,
  input  logic [asp_pkg::MaskW-1:0]   in_affinity_mask,
  input  logic [asp_pkg::MaskW-1:0]   in_query_mask,
  input  logic [asp_pkg::TimeW-1:0]   in_run_time,
  input  logic [asp_pkg::TimeW-1:0]   in_callback_return,
  input  asp_pkg::dp_cmd_t            cmd,
  output asp_pkg::dp_stat_t           stat,
  output logic                        out_valid,
  output logic [2:0]                  out_status,
  output logic [asp_pkg::IdW-1:0]     out_proc_id,
  output logic [asp_pkg::TimeW-1:0]   out_time_left,
  output logic [asp_pkg::NiceW-1:0]   out_niceness,
  output logic [asp_pkg::MaskW-1:0]   out_affinity_mask,
  output logic [asp_pkg::CntW-1:0]    out_entry_count
);

  asp_pkg::entry_t                 entries_r [asp_pkg::Capacity];
  logic [asp_pkg::CntW-1:0]        count_r;
  logic [asp_pkg::CntW-1:0]        idx_r;
  logic [asp_pkg::IdxW-1:0]        pos_r;
  asp_pkg::entry_t                 slot_r;
  asp_pkg::entry_t                 new_r;
  logic [2:0]                      func_r;
  logic [asp_pkg::MaskW-1:0]       q_r;
  logic [asp_pkg::TimeW-1:0]       rt_r, cb_r;
  logic [asp_pkg::KeyW-1:0]        key_r;
  logic [asp_pkg::BitsW-1:0]       bits_r;
  logic                            valid_r;
  logic [2:0]                      status_r;
  asp_pkg::entry_t                 res_r;
  logic [asp_pkg::CntW-1:0]        cnt_out_r;

  asp_pkg::entry_t                 cur;
  logic [asp_pkg::KeyW-1:0]        cur_key;
  logic [asp_pkg::BitsW-1:0]       cur_bits, slot_bits;
  logic [asp_pkg::TimeW-1:0]       left;
  logic [asp_pkg::TimeW:0]         sum;
  logic [asp_pkg::TimeW-1:0]       run_rem;

  assign cur     = entries_r[idx_r[asp_pkg::IdxW-1:0]];
  assign cur_key = asp_pkg::KeyW'(cur.rem) * asp_pkg::KeyW'(cur.nice);

  always_comb begin
    cur_bits  = '0;
    slot_bits = '0;
    for (int b = 0; b < asp_pkg::MaskW; b++) begin
      cur_bits  = cur_bits  + asp_pkg::BitsW'(cur.mask[b]);
      slot_bits = slot_bits + asp_pkg::BitsW'(slot_r.mask[b]);
    end
  end

  assign left    = (slot_r.rem > rt_r) ? slot_r.rem - rt_r : '0;
  assign sum     = {1'b0, left} + {1'b0, cb_r};
  assign run_rem = (cb_r == '0) ? '0 : (sum[asp_pkg::TimeW] ? asp_pkg::TimeMax :
                   sum[asp_pkg::TimeW-1:0]);

  always_comb begin
    stat.func     = func_r;
    stat.scan_end = (idx_r >= count_r);
    stat.id_hit   = (cur.id == new_r.id);
    stat.q_hit    = ((cur.mask & q_r) != '0);
    stat.go_past  = (key_r > cur_key) || (key_r == cur_key && bits_r > cur_bits);
    stat.full     = (count_r >= asp_pkg::CntW'(asp_pkg::Capacity));
    stat.same     = (slot_r.rem == new_r.rem) && (slot_r.nice == new_r.nice) &&
                    (slot_r.mask == new_r.mask);
    stat.cb_zero  = (cb_r == '0);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
      valid_r <= 1'b0;
    end else begin
      valid_r <= cmd.emit;
      if (cmd.remove) count_r <= count_r - asp_pkg::CntW'(1);
      else if (cmd.place) count_r <= count_r + asp_pkg::CntW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.latch) begin
      func_r      <= in_func;
      new_r.id    <= in_proc_id;
      new_r.rem   <= in_time_left;
      new_r.nice  <= asp_pkg::clamp_nice(in_niceness);
      new_r.mask  <= in_affinity_mask & asp_pkg::CpuBits;
      q_r         <= in_query_mask & asp_pkg::CpuBits;
      rt_r        <= in_run_time;
      cb_r        <= in_callback_return;
    end
    if (cmd.scan_rst) idx_r <= '0;
    else if (cmd.scan_inc) idx_r <= idx_r + asp_pkg::CntW'(1);
    if (cmd.mark) begin
      pos_r  <= idx_r[asp_pkg::IdxW-1:0];
      slot_r <= cur;
    end
    if (cmd.load_new) slot_r <= new_r;
    if (cmd.upd_run)  slot_r.rem  <= run_rem;
    if (cmd.upd_nice) slot_r.nice <= new_r.nice;
    if (cmd.calc_key) begin
      key_r  <= asp_pkg::KeyW'(slot_r.rem) * asp_pkg::KeyW'(slot_r.nice);
      bits_r <= slot_bits;
    end
    // close the gap at pos_r, or open one at idx_r
    for (int j = 0; j < asp_pkg::Capacity; j++) begin
      if (cmd.remove && j >= int'(pos_r) && j < asp_pkg::Capacity - 1)
        entries_r[j] <= entries_r[j+1];
      if (cmd.place) begin
        if (j == int'(idx_r)) entries_r[j] <= slot_r;
        else if (j > int'(idx_r)) entries_r[j] <= entries_r[j-1];
      end
    end
    if (cmd.emit) begin
      status_r  <= cmd.status;
      cnt_out_r <= count_r;
      unique case (cmd.sel)
        asp_pkg::SEL_SLOT: res_r <= slot_r;
        asp_pkg::SEL_ID:   res_r <= '{id: new_r.id, default: '0};
        default:           res_r <= '0;
      endcase
    end
  end

  assign out_valid          = valid_r;
  assign out_status         = status_r;
  assign out_proc_id        = res_r.id;
  assign out_time_left      = res_r.rem;
  assign out_niceness       = res_r.nice;
  assign out_affinity_mask  = res_r.mask;
  assign out_entry_count    = cnt_out_r;

endmodule

FILE: rtl/affinity_priority_scheduler_queue.sv
// Top level of the affinity priority scheduler queue.
// A command is taken when start is high and busy is low; its inputs are
// sampled in that cycle and need not be held afterwards.
// Each command gives exactly one result, shown for one cycle with out_valid
// high; the receiver cannot hold it off, so it must sample every strobe.
// The table holds up to 16 entries kept sorted by remaining time times
// niceness, fewer affinity bits first on a tie.
// A command scans the table entry by entry to find its target and, when an
// entry must be inserted or reinserted, scans again for the insertion point.
// The table has a single-entry scan port and key multiplier, which compare
// one entry per cycle.
// busy stays high from acceptance until the cycle that raises out_valid;
// the next command can be taken in the cycle that shows the result.
// Reset empties the table; no clearing pass is needed.
module affinity_priority_scheduler_queue (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        start,
  output logic                        busy,
  input  logic [2:0]                  in_func,
  input  logic [asp_pkg::IdW-1:0]     in_proc_id,
  input  logic [asp_pkg::TimeW-1:0]   in_time_left,
  input  logic [asp_pkg::NiceW-1:0]   in_niceness,
  input  logic [asp_pkg::MaskW-1:0]   in_affinity_mask,
  input  logic [asp_pkg::MaskW-1:0]   in_query_mask,
  input  logic [asp_pkg::TimeW-1:0]   in_run_time,
  input  logic [asp_pkg::TimeW-1:0]   in_callback_return,
  output logic                        out_valid,
  output logic [2:0]                  out_status,
  output logic [asp_pkg::IdW-1:0]     out_proc_id,
  output logic [asp_pkg::TimeW-1:0]   out_time_left,
  output logic [asp_pkg::NiceW-1:0]   out_niceness,
  output logic [asp_pkg::MaskW-1:0]   out_affinity_mask,
  output logic [asp_pkg::CntW-1:0]    out_entry_count
);

  asp_pkg::dp_cmd_t  cmd;
  asp_pkg::dp_stat_t stat;

  asp_ctrl u_ctrl (
    .clk   (clk),
    .rst_n (rst_n),
    .start (start),
    .busy  (busy),
    .stat  (stat),
    .cmd   (cmd)
  );

  asp_datapath u_dp (
    .clk                (clk),
    .rst_n              (rst_n),
    .in_func            (in_func),
    .in_proc_id         (in_proc_id),
    .in_time_left       (in_time_left),
    .in_niceness        (in_niceness),
    .in_affinity_mask   (in_affinity_mask),
    .in_query_mask      (in_query_mask),
    .in_run_time        (in_run_time),
    .in_callback_return (in_callback_return),
    .cmd                (cmd),
    .stat               (stat),
    .out_valid          (out_valid),
    .out_status         (out_status),
    .out_proc_id        (out_proc_id),
    .out_time_left      (out_time_left),
    .out_niceness       (out_niceness),
    .out_affinity_mask  (out_affinity_mask),
    .out_entry_count    (out_entry_count)
  );

endmodule

FILE: rtl/asp_checker.sv
// Port-level checker for the scheduler queue, bound to the top level.
module asp_checker (
  input logic                      clk,
  input logic                      rst_n,
  input logic                      start,
  input logic                      busy,
  input logic                      out_valid,
  input logic [2:0]                out_status,
  input logic [asp_pkg::TimeW-1:0] out_time_left,
  input logic [asp_pkg::MaskW-1:0] out_affinity_mask,
  input logic [asp_pkg::CntW-1:0]  out_entry_count
);

  a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    start && !busy |=> busy) else $error("busy not raised after accept");

  a_strobe_single: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |=> !out_valid) else $error("result strobe longer than one cycle");

  a_result_idle: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !busy) else $error("result shown while busy");

  a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_entry_count <= asp_pkg::CntW'(asp_pkg::Capacity))
    else $error("entry count out of range");

  a_none_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_status == asp_pkg::ST_NONE |->
      out_time_left == '0 && out_affinity_mask == '0)
    else $error("empty result carries data");

endmodule

bind affinity_priority_scheduler_queue asp_checker u_asp_checker (
  .clk                (clk),
  .rst_n              (rst_n),
  .start              (start),
  .busy               (busy),
  .out_valid          (out_valid),
  .out_status         (out_status),
  .out_time_left      (out_time_left),
  .out_affinity_mask  (out_affinity_mask),
  .out_entry_count    (out_entry_count)
);

FILE: tb/tb_affinity_priority_scheduler_queue.sv
// Self-checking testbench for the affinity priority scheduler queue.
module tb_affinity_priority_scheduler_queue;
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct {
    logic [2:0]                func;
    logic [asp_pkg::IdW-1:0]   id;
    logic [asp_pkg::TimeW-1:0] rem;
    logic [asp_pkg::NiceW-1:0] nice;
    logic [asp_pkg::MaskW-1:0] mask;
    logic [asp_pkg::MaskW-1:0] query;
    logic [asp_pkg::TimeW-1:0] run_t;
    logic [asp_pkg::TimeW-1:0] cb;
  } cmd_t;

  typedef struct {
    logic [2:0]                status;
    logic [asp_pkg::IdW-1:0]   id;
    logic [asp_pkg::TimeW-1:0] rem;
    logic [asp_pkg::NiceW-1:0] nice;
    logic [asp_pkg::MaskW-1:0] mask;
    logic [asp_pkg::CntW-1:0]  count;
  } resp_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic start = 1'b0;
  logic busy;
  logic [2:0]                in_func = '0;
  logic [asp_pkg::IdW-1:0]   in_proc_id = '0;
  logic [asp_pkg::TimeW-1:0] in_time_left = '0;
  logic [asp_pkg::NiceW-1:0] in_niceness = '0;
  logic [asp_pkg::MaskW-1:0] in_affinity_mask = '0;
  logic [asp_pkg::MaskW-1:0] in_query_mask = '0;
  logic [asp_pkg::TimeW-1:0] in_run_time = '0;
  logic [asp_pkg::TimeW-1:0] in_callback_return = '0;
  logic                      out_valid;
  logic [2:0]                out_status;
  logic [asp_pkg::IdW-1:0]   out_proc_id;
  logic [asp_pkg::TimeW-1:0] out_time_left;
  logic [asp_pkg::NiceW-1:0] out_niceness;
  logic [asp_pkg::MaskW-1:0] out_affinity_mask;
  logic [asp_pkg::CntW-1:0]  out_entry_count;

  affinity_priority_scheduler_queue uut (.*);

  always #10 clk = ~clk;

  cmd_t            pending_cmds[$];
  resp_t           expected_resps[$];
  asp_pkg::entry_t sched_tbl[asp_pkg::Capacity];
  int     sched_cnt = 0;
  int     fail_cnt = 0;
  int     stall_cnt = 0;
  bit     quiet = 1'b0;
  bit     stim_done = 1'b0;
  logic [asp_pkg::IdW-1:0] id_pool[$];

  function automatic logic [asp_pkg::NiceW-1:0] sat_nice(logic [asp_pkg::NiceW-1:0] v);
    if (v < 6'd10) return 6'd10;
    if (v > 6'd49) return 6'd49;
    return v;
  endfunction

  function automatic logic [29:0] prio_key(asp_pkg::entry_t e);
    return 30'(e.rem) * 30'(e.nice);
  endfunction

  function automatic void tbl_insert(asp_pkg::entry_t e);
    int p = 0;
    logic [29:0] k = prio_key(e);
    int b = $countones(e.mask);
    while (p < sched_cnt && (k > prio_key(sched_tbl[p]) ||
           (k == prio_key(sched_tbl[p]) && b > $countones(sched_tbl[p].mask))))
      p++;
    for (int i = sched_cnt; i > p; i--) sched_tbl[i] = sched_tbl[i-1];
    sched_tbl[p] = e;
    sched_cnt++;
  endfunction

  function automatic void tbl_remove(int p);
    for (int i = p; i + 1 < sched_cnt; i++) sched_tbl[i] = sched_tbl[i+1];
    sched_cnt--;
  endfunction

  function automatic int find_ident(logic [asp_pkg::IdW-1:0] id);
    for (int i = 0; i < sched_cnt; i++) if (sched_tbl[i].id == id) return i;
    return -1;
  endfunction

  function automatic int find_match(logic [asp_pkg::MaskW-1:0] q);
    for (int i = 0; i < sched_cnt; i++) if ((sched_tbl[i].mask & q) != 0) return i;
    return -1;
  endfunction

  // applies one command to the shadow table and returns the result it gives
  function automatic resp_t schedule_cmd(cmd_t c);
    resp_t r;
    asp_pkg::entry_t e;
    int p;
    logic [24:0] left;
    r = '{asp_pkg::ST_NONE, '0, '0, '0, '0, '0};
    case (c.func)
      asp_pkg::FN_PUSH: begin
        e = '{c.id, c.rem, sat_nice(c.nice), c.mask};
        p = find_ident(c.id);
        if (p >= 0) begin
          e = sched_tbl[p];
          r = '{(e.rem == c.rem && e.nice == sat_nice(c.nice) && e.mask == c.mask) ?
                asp_pkg::ST_DUP : asp_pkg::ST_INCON, e.id, e.rem, e.nice, e.mask, '0};
        end else if (sched_cnt >= asp_pkg::Capacity) begin
          r = '{asp_pkg::ST_FULL, c.id, '0, '0, '0, '0};
        end else begin
          tbl_insert(e);
          r = '{asp_pkg::ST_OK, e.id, e.rem, e.nice, e.mask, '0};
        end
      end
      asp_pkg::FN_PEEK, asp_pkg::FN_POP, asp_pkg::FN_RUN: begin
        p = find_match(c.query);
        if (p >= 0) begin
          e = sched_tbl[p];
          if (c.func != asp_pkg::FN_PEEK) tbl_remove(p);
          if (c.func == asp_pkg::FN_RUN) begin
            if (c.cb == 0) e.rem = '0;
            else begin
              left = (e.rem > c.run_t) ? 25'(e.rem - c.run_t) : 25'd0;
              left += 25'(c.cb);
              e.rem = left[24] ? asp_pkg::TimeMax : left[23:0];
              tbl_insert(e);
            end
          end
          r = '{asp_pkg::ST_OK, e.id, e.rem, e.nice, e.mask, '0};
        end
      end
      asp_pkg::FN_RENICE: begin
        p = find_ident(c.id);
        if (p >= 0) begin
          e = sched_tbl[p];
          e.nice = sat_nice(c.nice);
          tbl_remove(p);
          tbl_insert(e);
          r = '{asp_pkg::ST_OK, e.id, e.rem, e.nice, e.mask, '0};
        end
      end
      default: ;
    endcase
    r.count = asp_pkg::CntW'(sched_cnt);
    return r;
  endfunction

  // driver
  always @(posedge clk) begin
    if (rst_n) begin
      if (start && !busy) begin
        expected_resps.push_back(schedule_cmd(pending_cmds.pop_front()));
      end
      if ((!start || !busy) && pending_cmds.size() > 0 &&
          (quiet || $urandom_range(99) >= 6)) begin
        start <= 1'b1;
        in_func <= pending_cmds[0].func;
        in_proc_id <= pending_cmds[0].id;
        in_time_left <= pending_cmds[0].rem;
        in_niceness <= pending_cmds[0].nice;
        in_affinity_mask <= pending_cmds[0].mask;
        in_query_mask <= pending_cmds[0].query;
        in_run_time <= pending_cmds[0].run_t;
        in_callback_return <= pending_cmds[0].cb;
      end else if (!start || !busy) begin
        start <= 1'b0;
      end
    end
  end

  // monitor
  always @(posedge clk) begin
    resp_t want;
    if (rst_n && out_valid) begin
      if (expected_resps.size() == 0) begin
        $error("unexpected result status=%0d", out_status);
        fail_cnt++;
      end else begin
        want = expected_resps.pop_front();
        if (out_status !== want.status) begin
          $error("status exp %0d got %0d", want.status, out_status); fail_cnt++;
        end
        if (out_proc_id !== want.id) begin
          $error("proc_id exp %0h got %0h", want.id, out_proc_id); fail_cnt++;
        end
        if (out_time_left !== want.rem) begin
          $error("time_left exp %0h got %0h", want.rem, out_time_left);
          fail_cnt++;
        end
        if (out_niceness !== want.nice) begin
          $error("niceness exp %0d got %0d", want.nice, out_niceness); fail_cnt++;
        end
        if (out_affinity_mask !== want.mask) begin
          $error("affinity_mask exp %0h got %0h", want.mask, out_affinity_mask);
          fail_cnt++;
        end
        if (out_entry_count !== want.count) begin
          $error("entry_count exp %0d got %0d", want.count, out_entry_count); fail_cnt++;
        end
      end
    end
  end

  // watchdog: cycles without any accepted item or result
  always @(posedge clk) begin
    if ((start && !busy) || out_valid || !rst_n) stall_cnt <= 0;
    else stall_cnt <= stall_cnt + 1;
    if (stall_cnt > 2000 && !stim_done) begin
      $display("tb_affinity_priority_scheduler_queue: FAIL");
      $finish;
    end
  end

  function automatic logic [asp_pkg::TimeW-1:0] rand_time();
    case ($urandom_range(3))
      0: return asp_pkg::TimeW'($urandom_range(16));
      1: return asp_pkg::TimeW'($urandom_range(4095));
      2: return asp_pkg::TimeMax - asp_pkg::TimeW'($urandom_range(3));
      default: return asp_pkg::TimeW'($urandom);
    endcase
  endfunction

  function automatic logic [asp_pkg::MaskW-1:0] rand_mask();
    case ($urandom_range(3))
      0: return asp_pkg::MaskW'(1) << $urandom_range(15);
      1: return '1;
      default: return asp_pkg::MaskW'($urandom);
    endcase
  endfunction

  function automatic logic [asp_pkg::IdW-1:0] rand_ident();
    logic [asp_pkg::IdW-1:0] v;
    if (id_pool.size() > 0 && $urandom_range(3) != 0)
      return id_pool[$urandom_range(id_pool.size() - 1)];
    v = asp_pkg::IdW'($urandom);
    id_pool.push_back(v);
    if (id_pool.size() > 24) void'(id_pool.pop_front());
    return v;
  endfunction

  function automatic void add_cmd(logic [2:0] f, logic [asp_pkg::IdW-1:0] id,
                                  logic [asp_pkg::TimeW-1:0] rem,
                                  logic [asp_pkg::NiceW-1:0] nice,
                                  logic [asp_pkg::MaskW-1:0] mask,
                                  logic [asp_pkg::MaskW-1:0] q,
                                  logic [asp_pkg::TimeW-1:0] rt,
                                  logic [asp_pkg::TimeW-1:0] cb);
    cmd_t c;
    c = '{f, id, rem, nice, mask, q, rt, cb};
    pending_cmds.push_back(c);
  endfunction

  initial begin
    int roll;
    int timeout;
    logic [2:0] f;
    // directed: empty table misses, extremes, duplicates, full, unknown ops
    add_cmd(asp_pkg::FN_PEEK, 16'h0, 0, 0, 0, 16'hFFFF, 0, 0);
    add_cmd(asp_pkg::FN_RENICE, 16'h55, 0, 20, 0, 0, 0, 0);
    add_cmd(asp_pkg::FN_PUSH, 16'hFFFF, asp_pkg::TimeMax, 6'h3F, 16'hFFFF, 0, 0, 0);
    add_cmd(asp_pkg::FN_PUSH, 16'h0000, 24'd0, 6'd0, 16'h0000, 0, 0, 0);
    add_cmd(asp_pkg::FN_PUSH, 16'hFFFF, asp_pkg::TimeMax, 6'd49, 16'hFFFF, 0, 0, 0);
    add_cmd(asp_pkg::FN_PUSH, 16'hFFFF, asp_pkg::TimeMax, 6'd20, 16'hFFFF, 0, 0, 0);
    add_cmd(asp_pkg::FN_PUSH, 16'h0001, 24'd100, 6'd10, 16'h0003, 0, 0, 0);
    add_cmd(asp_pkg::FN_PUSH, 16'h0002, 24'd100, 6'd10, 16'h0001, 0, 0, 0);
    add_cmd(asp_pkg::FN_PEEK, 16'h0, 0, 0, 0, 16'h0002, 0, 0);
    add_cmd(asp_pkg::FN_RUN, 16'h0, 0, 0, 0, 16'h0001, 24'd500, 24'd7);
    add_cmd(asp_pkg::FN_RUN, 16'h0, 0, 0, 0, 16'h8000, 24'd0, asp_pkg::TimeMax);
    add_cmd(asp_pkg::FN_RUN, 16'h0, 0, 0, 0, 16'h0002, 24'd1, 24'd0);
    add_cmd(asp_pkg::FN_RENICE, 16'h0002, 0, 6'd63, 0, 0, 0, 0);
    add_cmd(asp_pkg::FN_RENICE, 16'h0002, 0, 6'd0, 0, 0, 0, 0);
    add_cmd(asp_pkg::FN_POP, 16'h0, 0, 0, 0, 16'hFFFF, 0, 0);
    add_cmd(3'd5, 16'h1234, 0, 0, 0, 16'hFFFF, 0, 0);
    add_cmd(3'd7, 16'hFFFF, asp_pkg::TimeMax, 6'h3F, 16'hFFFF, 16'hFFFF,
            asp_pkg::TimeMax, asp_pkg::TimeMax);
    for (int i = 0; i < 17; i++)
      add_cmd(asp_pkg::FN_PUSH, asp_pkg::IdW'(16'h100 + i), asp_pkg::TimeW'(i * 3),
              6'd25, 16'h0010, 0, 0, 0);
    add_cmd(asp_pkg::FN_PUSH, 16'h0100, 24'd0, 6'd25, 16'h0010, 0, 0, 0);
    for (int i = 0; i < 17; i++) add_cmd(asp_pkg::FN_POP, 0, 0, 0, 0, 16'hFFFF, 0, 0);

    // random: mostly meaningful ops on a recycled pool of identities
    for (int i = 0; i < 1300; i++) begin
      roll = $urandom_range(99);
      f = (roll < 35) ? asp_pkg::FN_PUSH : (roll < 45) ? asp_pkg::FN_PEEK :
          (roll < 60) ? asp_pkg::FN_POP : (roll < 85) ? asp_pkg::FN_RUN :
          (roll < 97) ? asp_pkg::FN_RENICE : 3'($urandom_range(7, 5));
      add_cmd(f, rand_ident(), rand_time(), 6'($urandom), rand_mask(),
              ($urandom_range(9) == 0) ? 16'h0 : rand_mask(), rand_time(),
              ($urandom_range(3) == 0) ? 24'd0 : rand_time());
    end

    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    // alternate long clean stretches with idling
    fork
      begin
        wait (pending_cmds.size() < 900);
        @(posedge clk) quiet <= 1'b1;
        wait (pending_cmds.size() < 600);
        @(posedge clk) quiet <= 1'b0;
      end
    join_none
    wait (pending_cmds.size() == 0);
    @(posedge clk);
    while (start) @(posedge clk);
    stim_done = 1'b1;
    timeout = 0;
    while (expected_resps.size() > 0 && timeout < 5000) begin
      @(posedge clk);
      timeout++;
    end
    repeat (50) @(posedge clk);
    if (fail_cnt == 0 && expected_resps.size() == 0)
      $display("tb_affinity_priority_scheduler_queue: PASS");
    else
      $display("tb_affinity_priority_scheduler_queue: FAIL");
    $finish;
  end
endmodule
